// File: design/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants for the byte taint shadow engine
// Window size, length limit, command codes, queue item and status structs.
// ----------------------------------------------------------------------------
package bts_pkg;

   // shadow window: one taint bit per byte address
   localparam int ADDR_BITS = 16;
   localparam int MAX_LEN = 4096;

   // fixed port widths
   localparam int REQ_ADDR_BITS = 16;
   localparam int REQ_LEN_BITS = 13;

   // saturated length needs to hold MAX_LEN itself
   localparam int LEN_BITS = $clog2(MAX_LEN + 1);
   localparam int LEN_CMP_BITS = (LEN_BITS > REQ_LEN_BITS) ? LEN_BITS : REQ_LEN_BITS;

   localparam int SHADOW_DEPTH = 2 ** ADDR_BITS;

   // command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [LEN_BITS-1:0] len_type;

   typedef enum logic [1:0] {
      OP_MARK  = 2'd0,
      OP_COPY  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_CHECK = 2'd3
   } op_type;

   typedef struct packed {
      op_type   op;
      addr_type src;
      addr_type dst;
      len_type  len;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic clearing;
   } bk_status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_RUN,
      BK_CHKWAIT
   } bk_state_type;

endpackage

// File: design/bts_front.sv
// ----------------------------------------------------------------------------
// bts_front: command intake
// Takes commands, decodes the op, wraps addresses and clamps the length,
// then pushes the item into the command queue.
// ----------------------------------------------------------------------------
module bts_front (
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_cmd,
   input  logic [bts_pkg::REQ_ADDR_BITS-1:0]     req_src_addr,
   input  logic [bts_pkg::REQ_ADDR_BITS-1:0]     req_dst_addr,
   input  logic [bts_pkg::REQ_LEN_BITS-1:0]      req_length,
   input  bts_pkg::q_status_type                 q_stat,
   input  bts_pkg::bk_status_type                bk_stat,
   output logic                                  push,
   output bts_pkg::item_type                     push_item
);
   import bts_pkg::*;

   logic [LEN_CMP_BITS-1:0] len_ext;
   op_type                  op;

   // no intake while the shadow store is being swept or the queue is full
   assign busy = q_stat.full || bk_stat.clearing;
   assign push = start && !busy;

   // all four command codes are valid ops
   assign op = op_type'(req_cmd);

   assign len_ext = LEN_CMP_BITS'(req_length);

   always_comb begin
      push_item.op  = op;
      push_item.src = ADDR_BITS'(req_src_addr);
      push_item.dst = ADDR_BITS'(req_dst_addr);
      if (len_ext > LEN_CMP_BITS'(MAX_LEN)) begin
         push_item.len = LEN_BITS'(MAX_LEN);
      end else begin
         push_item.len = LEN_BITS'(len_ext);
      end
   end

endmodule

// File: design/bts_queue.sv
// ----------------------------------------------------------------------------
// bts_queue: command queue
// Small FIFO of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module bts_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bts_pkg::item_type      push_item,
   input  logic                   pop,
   output bts_pkg::item_type      head_item,
   output bts_pkg::q_status_type  q_stat
);
   import bts_pkg::*;

   item_type                entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign q_stat.full  = (cnt_ff == Q_CNT_BITS'(Q_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/bts_back.sv
// ----------------------------------------------------------------------------
// bts_back: range walker and shadow store
// Owns the taint bit memory; sweeps it clear after reset, then walks one
// byte per cycle for mark, copy and clear, and reads one bit for check.
// ----------------------------------------------------------------------------
module bts_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bts_pkg::item_type       head_item,
   input  bts_pkg::q_status_type   q_stat,
   output logic                    pop,
   output bts_pkg::bk_status_type  bk_stat,
   output logic                    rsp_valid,
   output logic                    rsp_tainted_hit
);
   import bts_pkg::*;

   bk_state_type state_ff, state_in;

   op_type    op_ff, op_in;
   addr_type  src_ff, src_in;
   addr_type  dst_ff, dst_in;
   len_type   cnt_ff, cnt_in;
   addr_type  clr_cnt_ff, clr_cnt_in;
   logic      pend_ff, pend_in;        // copy read in flight
   addr_type  pend_dst_ff, pend_dst_in;

   // shadow store
   logic      shadow_mem [SHADOW_DEPTH];
   logic      wr_en, wr_data, rd_en;
   addr_type  wr_addr, rd_addr;
   logic      rd_data_ff;
   logic      byp_ff, byp_in, byp_data_ff;
   logic      rd_bit;

   logic      done, hit;
   logic      rsp_valid_ff, rsp_hit_ff;

   // a write to the address being read in the same cycle wins
   assign rd_bit = byp_ff ? byp_data_ff : rd_data_ff;
   assign byp_in = wr_en && rd_en && (wr_addr == rd_addr);

   assign bk_stat.clearing = (state_ff == BK_CLEAR);
   assign pop = (state_ff == BK_IDLE) && !q_stat.empty;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_cnt_ff == '1) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (!q_stat.empty) state_in = BK_RUN;
         end
         BK_RUN: begin
            if (op_ff == OP_CHECK) begin
               state_in = BK_CHKWAIT;
            end else if (cnt_ff == '0) begin
               state_in = BK_IDLE;
            end
         end
         BK_CHKWAIT: begin
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = dst_ff;
      wr_data     = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = src_ff;
      done        = 1'b0;
      hit         = 1'b0;
      op_in       = op_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      cnt_in      = cnt_ff;
      clr_cnt_in  = clr_cnt_ff;
      pend_in     = 1'b0;
      pend_dst_in = pend_dst_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = 1'b0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         BK_IDLE: begin
            if (!q_stat.empty) begin
               op_in  = head_item.op;
               src_in = head_item.src;
               dst_in = head_item.dst;
               cnt_in = head_item.len;
            end
         end
         BK_RUN: begin
            unique case (op_ff)
               OP_MARK, OP_CLEAR: begin
                  if (cnt_ff == '0) begin
                     done = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = dst_ff;
                     wr_data = (op_ff == OP_MARK);
                     dst_in  = dst_ff + 1'b1;
                     cnt_in  = cnt_ff - 1'b1;
                  end
               end
               OP_COPY: begin
                  // finish the previous byte, issue the next source read
                  if (pend_ff && rd_bit) begin
                     wr_en   = 1'b1;
                     wr_addr = pend_dst_ff;
                     wr_data = 1'b1;
                  end
                  if (cnt_ff == '0) begin
                     done = 1'b1;
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = src_ff;
                     pend_in     = 1'b1;
                     pend_dst_in = dst_ff;
                     src_in      = src_ff + 1'b1;
                     dst_in      = dst_ff + 1'b1;
                     cnt_in      = cnt_ff - 1'b1;
                  end
               end
               default: begin
                  rd_en   = 1'b1;
                  rd_addr = src_ff;
               end
            endcase
         end
         BK_CHKWAIT: begin
            done = 1'b1;
            hit  = rd_bit;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= done;
         rsp_hit_ff   <= done && hit;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      cnt_ff      <= cnt_in;
      pend_dst_ff <= pend_dst_in;
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         shadow_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= shadow_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tainted_hit = rsp_hit_ff;

endmodule

// File: design/byte_taint_shadow_engine_unit.sv
// ----------------------------------------------------------------------------
// byte_taint_shadow_engine_unit: one-bit-per-byte taint shadow store
// Mark, copy, clear and check commands over a wrapping address window.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: drive req_* and raise start; the item is taken at the
//    clock edge where start is high and busy is low. busy is high while the
//    two-entry command queue is full or the store is being swept.
//  - Result channel: one item per command, shown on rsp_tainted_hit for a
//    single cycle with rsp_valid high. The receiver cannot stall, so results
//    are never held. rsp_tainted_hit is 0 for everything but check.
//  - Back end (one memory write port, one read port, one byte per cycle):
//    mark/clear write each byte, copy overlaps each source read with the
//    previous byte's destination write, and check reads one bit. The result
//    is registered and shows in the cycle after the back end finishes.
//    Lengths above MAX_LEN are clamped; addresses wrap at the window edge.
//  - Queue: the front keeps taking commands while the back end walks a range,
//    until the queue fills.
//  - Reset: synchronous. Afterwards the back end sweeps the whole store to
//    zero, one bit per cycle; busy stays high for that whole sweep.
// ----------------------------------------------------------------------------
module byte_taint_shadow_engine_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_cmd,
   input  logic [bts_pkg::REQ_ADDR_BITS-1:0]    req_src_addr,
   input  logic [bts_pkg::REQ_ADDR_BITS-1:0]    req_dst_addr,
   input  logic [bts_pkg::REQ_LEN_BITS-1:0]     req_length,
   output logic                                 rsp_valid,
   output logic                                 rsp_tainted_hit
);
   import bts_pkg::*;

   item_type       push_item;
   item_type       head_item;
   logic           push;
   logic           pop;
   q_status_type   q_stat;
   bk_status_type  bk_stat;

   // front: decode, clamp, push
   bts_front u_front (
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_src_addr (req_src_addr),
      .req_dst_addr (req_dst_addr),
      .req_length   (req_length),
      .q_stat       (q_stat),
      .bk_stat      (bk_stat),
      .push         (push),
      .push_item    (push_item)
   );

   // decouples intake from the range walk
   bts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   // back: shadow store, walker, result register
   bts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_item       (head_item),
      .q_stat          (q_stat),
      .pop             (pop),
      .bk_stat         (bk_stat),
      .rsp_valid       (rsp_valid),
      .rsp_tainted_hit (rsp_tainted_hit)
   );

endmodule

// File: design/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker: port-level checks for the taint shadow engine
// Watches reset behavior, result strobe spacing and the hit flag on the top-level ports.
// ----------------------------------------------------------------------------
module bts_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 busy,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_tainted_hit
);

   // store sweep starts right after reset, so no intake
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // each item needs at least a dispatch and a finish cycle
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in back-to-back cycles");

   a_hit_needs_strobe: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_tainted_hit)
      else $error("hit flag without result strobe");

endmodule

bind byte_taint_shadow_engine_unit bts_checker u_bts_checker (.*);
